FILE: rtl/rcp_pkg.sv
// Shared types, codes and character constants of the RESP command parser.
package rcp_pkg;

    typedef logic [3:0] t_phase;

    localparam t_phase PH_IDLE      = 4'd0;
    localparam t_phase PH_CNT_DIG   = 4'd1;
    localparam t_phase PH_CNT_LF    = 4'd2;
    localparam t_phase PH_TYP_DOL   = 4'd3;
    localparam t_phase PH_TYP_DIG   = 4'd4;
    localparam t_phase PH_TYP_LLF   = 4'd5;
    localparam t_phase PH_TYP_BYTES = 4'd6;
    localparam t_phase PH_TYP_CR    = 4'd7;
    localparam t_phase PH_TYP_LF    = 4'd8;
    localparam t_phase PH_ARG_DOL   = 4'd9;
    localparam t_phase PH_ARG_DIG   = 4'd10;
    localparam t_phase PH_ARG_LLF   = 4'd11;
    localparam t_phase PH_ARG_BYTES = 4'd12;
    localparam t_phase PH_ARG_CR    = 4'd13;
    localparam t_phase PH_ARG_LF    = 4'd14;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_GET  = 2'd1;
    localparam logic [1:0] CMD_SET  = 2'd2;
    localparam logic [1:0] CMD_DEL  = 2'd3;

    localparam logic [1:0] EV_FRAME   = 2'd0;
    localparam logic [1:0] EV_PAYLOAD = 2'd1;
    localparam logic [1:0] EV_DONE    = 2'd2;
    localparam logic [1:0] EV_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_STAR  = 3'd1;
    localparam logic [2:0] ERR_NO_DOL   = 3'd2;
    localparam logic [2:0] ERR_NO_DIGIT = 3'd3;
    localparam logic [2:0] ERR_NO_CRLF  = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd5;
    localparam logic [2:0] ERR_MISSING  = 3'd6;
    localparam logic [2:0] ERR_TOO_BIG  = 3'd7;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_DOL  = 8'h24;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [23:0] TYPE_GET = 24'h474554;
    localparam logic [23:0] TYPE_SET = 24'h534554;
    localparam logic [23:0] TYPE_DEL = 24'h44454C;

    // Largest element count that the count field may carry.
    localparam logic [15:0] COUNT_CAP = 16'd255;
    localparam logic [15:0] MAX_BULK_RESET = 16'hFFFF;

    typedef struct packed {
        logic [1:0] event_res;
        logic [1:0] command;
        logic [7:0] arg_index;
        logic       role;
        logic [7:0] payload_byte;
        logic       arg_last;
        logic [2:0] error_code;
    } t_result;

endpackage

FILE: rtl/rcp_parser.sv
// Parse state registers and the per-byte next-state and result logic.
module rcp_parser import rcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_max_len,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_accum, n_accum;
    logic        r_seen, n_seen;
    logic [7:0]  r_elems, n_elems;
    logic [7:0]  r_strings, n_strings;
    logic [15:0] r_bytes, n_bytes;
    logic [1:0]  r_kind, n_kind;
    logic [23:0] r_type, n_type;
    logic [7:0]  r_arg, n_arg;

    logic        fail, clr, is_digit;
    logic [2:0]  err;
    logic [1:0]  ev;
    logic        role, last;
    logic [7:0]  pay;
    logic [15:0] lim;
    logic [19:0] accum_x10;
    logic [23:0] type_shift;
    logic [15:0] bytes_dec;
    logic [7:0]  elems_dec, strings_dec;

    always_comb begin
        is_digit    = i_byte inside {[CH_ZERO:CH_NINE]};
        lim         = (r_phase == PH_CNT_DIG && i_max_len > COUNT_CAP) ? COUNT_CAP : i_max_len;
        accum_x10   = {4'd0, r_accum} * 20'd10 + {16'd0, i_byte[3:0]};
        type_shift  = {r_type[15:0], i_byte};
        bytes_dec   = r_bytes - 16'd1;
        elems_dec   = r_elems - 8'd1;
        strings_dec = r_strings - 8'd1;

        n_phase   = r_phase;
        n_accum   = r_accum;
        n_seen    = r_seen;
        n_elems   = r_elems;
        n_strings = r_strings;
        n_bytes   = r_bytes;
        n_kind    = r_kind;
        n_type    = r_type;
        n_arg     = r_arg;
        fail = 1'b0;
        clr  = 1'b0;
        err  = ERR_NONE;
        ev   = EV_FRAME;
        role = 1'b0;
        last = 1'b0;
        pay  = 8'd0;

        case (r_phase)
            PH_IDLE: begin
                if (i_byte != CH_STAR) begin
                    fail = 1'b1;
                    err  = ERR_NO_STAR;
                end else begin
                    n_accum = 16'd0;
                    n_seen  = 1'b0;
                    n_phase = PH_CNT_DIG;
                end
            end
            PH_CNT_DIG, PH_TYP_DIG, PH_ARG_DIG: begin
                if (is_digit) begin
                    if (accum_x10 > {4'd0, lim}) begin
                        fail = 1'b1;
                        err  = ERR_TOO_BIG;
                    end else begin
                        n_accum = accum_x10[15:0];
                        n_seen  = 1'b1;
                    end
                end else if (!r_seen) begin
                    fail = 1'b1;
                    err  = ERR_NO_DIGIT;
                end else if (i_byte != CH_CR) begin
                    fail = 1'b1;
                    err  = ERR_NO_CRLF;
                end else begin
                    n_phase = r_phase + 4'd1;
                end
            end
            PH_CNT_LF: begin
                if (i_byte != CH_LF) begin
                    fail = 1'b1;
                    err  = ERR_NO_CRLF;
                end else begin
                    n_elems = r_accum[7:0];
                    n_phase = PH_TYP_DOL;
                end
            end
            PH_TYP_DOL, PH_ARG_DOL: begin
                if (i_byte != CH_DOL) begin
                    fail = 1'b1;
                    err  = ERR_NO_DOL;
                end else begin
                    n_accum = 16'd0;
                    n_seen  = 1'b0;
                    n_phase = r_phase + 4'd1;
                end
            end
            PH_TYP_LLF: begin
                if (i_byte != CH_LF) begin
                    fail = 1'b1;
                    err  = ERR_NO_CRLF;
                end else if (r_accum == 16'd0) begin
                    fail = 1'b1;
                    err  = ERR_UNKNOWN;
                end else begin
                    n_bytes = r_accum;
                    n_type  = 24'd0;
                    n_phase = PH_TYP_BYTES;
                end
            end
            PH_TYP_BYTES: begin
                n_type  = type_shift;
                n_bytes = bytes_dec;
                if (bytes_dec == 16'd0) begin
                    // Type string is complete: it must be exactly three known bytes
                    if (r_accum == 16'd3 && type_shift == TYPE_GET) begin
                        n_kind  = CMD_GET;
                        n_phase = PH_TYP_CR;
                    end else if (r_accum == 16'd3 && type_shift == TYPE_SET) begin
                        n_kind  = CMD_SET;
                        n_phase = PH_TYP_CR;
                    end else if (r_accum == 16'd3 && type_shift == TYPE_DEL) begin
                        n_kind  = CMD_DEL;
                        n_phase = PH_TYP_CR;
                    end else begin
                        fail = 1'b1;
                        err  = ERR_UNKNOWN;
                    end
                end
            end
            PH_TYP_CR, PH_ARG_CR: begin
                if (i_byte != CH_CR) begin
                    fail = 1'b1;
                    err  = ERR_NO_CRLF;
                end else begin
                    n_phase = r_phase + 4'd1;
                end
            end
            PH_TYP_LF: begin
                if (i_byte != CH_LF) begin
                    fail = 1'b1;
                    err  = ERR_NO_CRLF;
                end else if (r_kind == CMD_SET) begin
                    if (r_elems < 8'd2) begin
                        fail = 1'b1;
                        err  = ERR_MISSING;
                    end else begin
                        n_strings = (elems_dec > 8'd2) ? elems_dec : 8'd2;
                        n_arg     = 8'd0;
                        n_phase   = PH_ARG_DOL;
                    end
                end else begin
                    if (r_elems == 8'd0) begin
                        fail = 1'b1;
                        err  = ERR_MISSING;
                    end else begin
                        n_strings = (r_elems > 8'd1) ? elems_dec : 8'd1;
                        n_arg     = 8'd0;
                        n_phase   = PH_ARG_DOL;
                    end
                end
            end
            PH_ARG_LLF: begin
                if (i_byte != CH_LF) begin
                    fail = 1'b1;
                    err  = ERR_NO_CRLF;
                end else begin
                    n_bytes = r_accum;
                    n_phase = (r_accum == 16'd0) ? PH_ARG_CR : PH_ARG_BYTES;
                end
            end
            PH_ARG_BYTES: begin
                ev      = EV_PAYLOAD;
                pay     = i_byte;
                role    = (r_kind == CMD_SET) && (r_arg != 8'd0);
                n_bytes = bytes_dec;
                last    = (bytes_dec == 16'd0);
                if (bytes_dec == 16'd0) begin
                    n_phase = PH_ARG_CR;
                end
            end
            PH_ARG_LF: begin
                if (i_byte != CH_LF) begin
                    fail = 1'b1;
                    err  = ERR_NO_CRLF;
                end else begin
                    n_arg     = r_arg + 8'd1;
                    n_strings = strings_dec;
                    if (strings_dec == 8'd0) begin
                        ev  = EV_DONE;
                        clr = 1'b1;
                    end else begin
                        n_phase = PH_ARG_DOL;
                    end
                end
            end
            default: begin
                fail = 1'b1;
                err  = ERR_NO_STAR;
            end
        endcase

        o_res.event_res    = fail ? EV_ERROR : ev;
        o_res.command      = n_kind;
        o_res.arg_index    = n_arg;
        o_res.role         = fail ? 1'b0 : role;
        o_res.payload_byte = fail ? 8'd0 : pay;
        o_res.arg_last     = fail ? 1'b0 : last;
        o_res.error_code   = err;
    end

    // Drop back to the start of a request on reset, after an error or a finished command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && (fail || clr))) begin
            r_phase   <= PH_IDLE;
            r_accum   <= 16'd0;
            r_seen    <= 1'b0;
            r_elems   <= 8'd0;
            r_strings <= 8'd0;
            r_bytes   <= 16'd0;
            r_kind    <= CMD_NONE;
            r_type    <= 24'd0;
            r_arg     <= 8'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_accum   <= n_accum;
            r_seen    <= n_seen;
            r_elems   <= n_elems;
            r_strings <= n_strings;
            r_bytes   <= n_bytes;
            r_kind    <= n_kind;
            r_type    <= n_type;
            r_arg     <= n_arg;
        end
    end

endmodule

FILE: rtl/resp_command_parser_core.sv
// Top level of the RESP command parser: input beat register, parser, result register.
//
// Byte stream in on the s-side (one request byte per beat in tdata), one event
// per byte out on the m-side. Every input byte yields exactly one output beat:
// framing, argument payload byte (tlast marks the final byte of an argument),
// command complete or syntax error with its code. Output tuser carries the
// event kind and the key/value role; tdata carries command, argument index,
// payload byte and error code.
// A byte accepted into the input register is parsed and stored in the result
// register, which drives o_m_tvalid. Throughput is one byte per cycle while
// the receiver does not stall; the parser state machine updates on the same
// edge that moves the byte from the input register into the result register.
// When the receiver stalls, the result register holds and the input register
// keeps one further byte, so o_s_tready drops once both are full and rises again
// as soon as the result beat is taken.
// Reset (synchronous, active low) empties both registers, puts the parser at
// the start of a request and sets max_bulk_len to 65535. The config channel
// is always ready; write it only while no byte is in flight.
module resp_command_parser_core import rcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [1:0] command, [9:2] arg_index,
                                     // [17:10] payload_byte, [20:18] error_code
    output logic [2:0]  o_m_tuser,   // [1:0] event_res, [2] role
    output logic        o_m_tlast,   // arg_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data   // max_bulk_len
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_max_len;
    logic        advance;
    t_result     res;

    // Move a byte through the parser whenever the result slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_BULK_RESET;
        end else if (i_cfg_valid) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    rcp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out.error_code, r_out.payload_byte,
                         r_out.arg_index, r_out.command};
    assign o_m_tuser  = {r_out.role, r_out.event_res};
    assign o_m_tlast  = r_out.arg_last;

endmodule

FILE: tb/sv/resp_command_parser_core_test.sv
// Self-checking testbench for resp_command_parser_core: byte stream in, one checked event per byte.
module resp_command_parser_core_test;
    import rcp_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data  = '0;

    resp_command_parser_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Request bytes waiting for the driver and events waiting for the monitor.
    logic [7:0] pending_bytes[$];
    t_result    results_due[$];

    int  mismatches   = 0;
    int  events_seen  = 0;
    int  tx_idle_pct  = 0;
    int  rx_idle_pct  = 0;
    int  rx_hold_left = 0;
    bit  in_taken     = 1'b0;
    bit  cfg_taken    = 1'b0;

    // Parser state mirrored from the block.
    logic [15:0] cfg_max_len = MAX_BULK_RESET;
    t_phase      st_phase    = PH_IDLE;
    logic [16:0] st_acc      = '0;
    logic        st_digit    = 1'b0;
    logic [7:0]  st_elems    = '0;
    logic [7:0]  st_strings  = '0;
    logic [16:0] st_bytes    = '0;
    logic [1:0]  st_cmd      = CMD_NONE;
    logic [23:0] st_type     = '0;
    logic [7:0]  st_argn     = '0;

    function automatic t_result parse_byte(logic [7:0] b);
        t_result     r;
        logic [2:0]  err;
        logic        restart;
        logic [15:0] lim;
        int          v;
        r       = '0;
        err     = ERR_NONE;
        restart = 1'b0;
        r.event_res = EV_FRAME;
        case (st_phase)
            PH_IDLE: begin
                if (b != CH_STAR) err = ERR_NO_STAR;
                else begin
                    st_acc   = '0;
                    st_digit = 1'b0;
                    st_phase = PH_CNT_DIG;
                end
            end
            PH_CNT_DIG, PH_TYP_DIG, PH_ARG_DIG: begin
                lim = (st_phase == PH_CNT_DIG && cfg_max_len > COUNT_CAP) ? COUNT_CAP
                                                                          : cfg_max_len;
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    v = int'(st_acc) * 10 + int'(b - CH_ZERO);
                    if (v > lim) err = ERR_TOO_BIG;
                    else begin
                        st_acc   = v[16:0];
                        st_digit = 1'b1;
                    end
                end else if (!st_digit) err = ERR_NO_DIGIT;
                else if (b != CH_CR) err = ERR_NO_CRLF;
                else st_phase = st_phase + 4'd1;
            end
            PH_CNT_LF: begin
                if (b != CH_LF) err = ERR_NO_CRLF;
                else begin
                    st_elems = st_acc[7:0];
                    st_phase = PH_TYP_DOL;
                end
            end
            PH_TYP_DOL, PH_ARG_DOL: begin
                if (b != CH_DOL) err = ERR_NO_DOL;
                else begin
                    st_acc   = '0;
                    st_digit = 1'b0;
                    st_phase = st_phase + 4'd1;
                end
            end
            PH_TYP_LLF: begin
                if (b != CH_LF) err = ERR_NO_CRLF;
                else begin
                    st_bytes = st_acc;
                    st_type  = '0;
                    if (st_acc == 0) err = ERR_UNKNOWN;
                    else st_phase = PH_TYP_BYTES;
                end
            end
            PH_TYP_BYTES: begin
                st_type  = {st_type[15:0], b};
                st_bytes = st_bytes - 17'd1;
                if (st_bytes == 0) begin
                    // type must be exactly three bytes and one of the known names
                    if (st_acc != 3) err = ERR_UNKNOWN;
                    else if (st_type == TYPE_GET) st_cmd = CMD_GET;
                    else if (st_type == TYPE_SET) st_cmd = CMD_SET;
                    else if (st_type == TYPE_DEL) st_cmd = CMD_DEL;
                    else err = ERR_UNKNOWN;
                    if (err == ERR_NONE) st_phase = PH_TYP_CR;
                end
            end
            PH_TYP_CR, PH_ARG_CR: begin
                if (b != CH_CR) err = ERR_NO_CRLF;
                else st_phase = st_phase + 4'd1;
            end
            PH_TYP_LF: begin
                if (b != CH_LF) err = ERR_NO_CRLF;
                else if (st_cmd == CMD_SET) begin
                    if (st_elems < 2) err = ERR_MISSING;
                    else st_strings = (st_elems > 8'd3) ? st_elems - 8'd1 : 8'd2;
                end else begin
                    if (st_elems == 0) err = ERR_MISSING;
                    else st_strings = (st_elems > 8'd1) ? st_elems - 8'd1 : 8'd1;
                end
                if (err == ERR_NONE) begin
                    st_argn  = '0;
                    st_phase = PH_ARG_DOL;
                end
            end
            PH_ARG_LLF: begin
                if (b != CH_LF) err = ERR_NO_CRLF;
                else begin
                    st_bytes = st_acc;
                    st_phase = (st_acc == 0) ? PH_ARG_CR : PH_ARG_BYTES;
                end
            end
            PH_ARG_BYTES: begin
                st_bytes       = st_bytes - 17'd1;
                r.event_res    = EV_PAYLOAD;
                r.role         = (st_cmd == CMD_SET && st_argn != 0);
                r.payload_byte = b;
                r.arg_last     = (st_bytes == 0);
                if (st_bytes == 0) st_phase = PH_ARG_CR;
            end
            PH_ARG_LF: begin
                if (b != CH_LF) err = ERR_NO_CRLF;
                else begin
                    st_argn    = st_argn + 8'd1;
                    st_strings = st_strings - 8'd1;
                    if (st_strings == 0) begin
                        r.event_res = EV_DONE;
                        restart     = 1'b1;
                    end else st_phase = PH_ARG_DOL;
                end
            end
            default: err = ERR_NO_STAR;
        endcase
        if (err != ERR_NONE) begin
            r.event_res = EV_ERROR;
            restart     = 1'b1;
        end
        r.error_code = err;
        r.command    = st_cmd;
        r.arg_index  = st_argn;
        if (restart) begin
            st_phase   = PH_IDLE;
            st_acc     = '0;
            st_digit   = 1'b0;
            st_elems   = '0;
            st_strings = '0;
            st_bytes   = '0;
            st_cmd     = CMD_NONE;
            st_type    = '0;
            st_argn    = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at event %0d: %s got %0d want %0d",
                 events_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_event(t_result got, t_result want);
        if (got.event_res != want.event_res)
            report_mismatch("event_res", got.event_res, want.event_res);
        if (got.command != want.command)
            report_mismatch("command", got.command, want.command);
        if (got.arg_index != want.arg_index)
            report_mismatch("arg_index", got.arg_index, want.arg_index);
        if (got.role != want.role)
            report_mismatch("role", got.role, want.role);
        if (got.payload_byte != want.payload_byte)
            report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
        if (got.arg_last != want.arg_last)
            report_mismatch("arg_last", got.arg_last, want.arg_last);
        if (got.error_code != want.error_code)
            report_mismatch("error_code", got.error_code, want.error_code);
    endtask

    // Monitor: check output beats first, then predict the byte taken at this edge.
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_max_len = i_cfg_data;
                cfg_taken   = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.event_res    = o_m_tuser[1:0];
                got.role         = o_m_tuser[2];
                got.command      = o_m_tdata[1:0];
                got.arg_index    = o_m_tdata[9:2];
                got.payload_byte = o_m_tdata[17:10];
                got.error_code   = o_m_tdata[20:18];
                got.arg_last     = o_m_tlast;
                if (results_due.size() == 0) report_mismatch("unexpected beat", 1, 0);
                else check_event(got, results_due.pop_front());
                events_seen++;
            end
            in_taken = i_s_tvalid && o_s_tready;
            if (in_taken) results_due = {results_due, parse_byte(i_s_tdata)};
        end
    end

    // Driver: offer the next byte once the current beat is gone.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || in_taken)) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_bytes.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off while rx_hold_left counts down.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_m_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic push_byte(logic [7:0] b);
        pending_bytes = {pending_bytes, b};
    endtask

    task automatic push_text(string s);
        for (int k = 0; k < s.len(); k++) push_byte(s[k]);
    endtask

    task automatic push_line(string s);
        push_text(s);
        push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic push_bulk(int len);
        push_line($sformatf("$%0d", len));
        repeat (len) push_byte(8'($urandom_range(0, 255)));
        push_line("");
    endtask

    function automatic int pick_len();
        int len;
        if (cfg_max_len <= 300 && $urandom_range(0, 29) == 0) begin
            len = int'(cfg_max_len) + $urandom_range(0, 2) - 1;
            if (len < 0) len = 0;
        end else if ($urandom_range(0, 4) == 0) begin
            len = 0;
        end else begin
            len = $urandom_range(1, 6);
        end
        return len;
    endfunction

    // One request with random content; some are broken afterwards, some are pure noise.
    task automatic gen_request();
        int n;
        int nstr;
        int mark;
        int cnt_lim;
        int kind;
        int len;
        mark    = pending_bytes.size();
        cnt_lim = (cfg_max_len < COUNT_CAP) ? int'(cfg_max_len) : int'(COUNT_CAP);
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
        end else begin
            if (cnt_lim <= 12 && $urandom_range(0, 3) == 0) n = cnt_lim + $urandom_range(0, 1);
            else if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 12);
            else n = $urandom_range(1, 4);
            push_text("*");
            if ($urandom_range(0, 7) == 0) push_text("0");
            push_line($sformatf("%0d", n));
            kind = $urandom_range(0, 11);
            nstr = (n > 1) ? n - 1 : 1;
            if (kind == 0) begin
                // unknown type: random upper-case letters of random length
                len = $urandom_range(0, 4);
                push_line($sformatf("$%0d", len));
                repeat (len) push_byte(8'($urandom_range(8'h41, 8'h5A)));
                push_line("");
            end else begin
                push_line("$3");
                case (kind % 3)
                    0:       push_line("GET");
                    1: begin
                        push_line("SET");
                        if (nstr < 2) nstr = 2;
                    end
                    default: push_line("DEL");
                endcase
            end
            repeat (nstr) push_bulk(pick_len());
            if ($urandom_range(0, 6) == 0)
                pending_bytes[$urandom_range(mark, pending_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
            else if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) void'(pending_bytes.pop_back());
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_s_tvalid || results_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_max_len(logic [15:0] value);
        cfg_taken = 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(negedge i_clk);
        while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    logic [15:0] max_len_steps[7] = '{16'hFFFF, 16'd0, 16'd3, 16'd9, 16'd100, 16'd255, 16'hFFFF};

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 33;
        rx_idle_pct = 69;

        // no array marker, empty count, bad line ends, count too large
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("*");
        push_byte(CH_CR);
        push_text("*1x");
        push_text("*1");
        push_byte(CH_CR);
        push_text("x");
        push_text("*256");
        // no '$', empty and unknown types, missing arguments
        push_line("*1");
        push_text("x");
        push_line("*1");
        push_line("$0");
        push_line("*1");
        push_line("$3");
        push_text("GEX");
        push_line("*1");
        push_line("$4");
        push_text("GETS");
        push_line("*0");
        push_line("$3");
        push_line("GET");
        push_line("*1");
        push_line("$3");
        push_line("SET");
        push_line("*0");
        push_line("$3");
        push_line("DEL");
        // bulk length too large
        push_line("*1");
        push_line("$3");
        push_line("GET");
        push_text("$65536");
        // well-formed: empty key, key/value, extreme payload bytes, joined key, empty value
        push_line("*001");
        push_line("$3");
        push_line("GET");
        push_line("$0");
        push_line("");
        push_line("*3");
        push_line("$3");
        push_line("SET");
        push_line("$1");
        push_line("k");
        push_line("$2");
        push_line("v1");
        push_line("*2");
        push_line("$3");
        push_line("DEL");
        push_line("$2");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_line("");
        push_line("*3");
        push_line("$3");
        push_line("GET");
        push_line("$1");
        push_line("a");
        push_line("$1");
        push_line("b");
        push_line("*2");
        push_line("$3");
        push_line("SET");
        push_line("$1");
        push_line("k");
        push_line("$0");
        push_line("");
        // payload longer than its length, CR without LF, largest count
        push_line("*1");
        push_line("$3");
        push_line("GET");
        push_line("$1");
        push_text("ab");
        push_line("*1");
        push_line("$3");
        push_line("GET");
        push_line("$1");
        push_text("a");
        push_byte(CH_CR);
        push_text("x");
        push_line("*255");
        push_line("$3");
        push_line("DEL");
        push_text("x");
        wait_idle();

        foreach (max_len_steps[i]) begin
            if (i >= 5) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (i >= 2) begin
                tx_idle_pct = 69;
                rx_idle_pct = 33;
            end
            write_max_len(max_len_steps[i]);
            while (pending_bytes.size() < 80) gen_request();
            // hold the receiver so the block fills up and stalls its input
            if (i == 0) rx_hold_left = 300;
            wait_idle();
        end

        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("resp_command_parser_core_test: done, clean");
        end else begin
            $display("resp_command_parser_core_test: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("resp_command_parser_core_test: done, errors");
        $finish;
    end

endmodule
